>>> hdl/swcsm_pkg.sv
// Shared constants and types for the sliding-window chunk slot manager.
// No dependencies; imported by swcsm_div and the top level.
package swcsm_pkg;

    // Fixed field widths
    localparam int TILE_W     = 16;          // center tile coordinate
    localparam int CHUNK_W    = 11;          // chunk coordinate, wraps modulo 2^11
    localparam int SLOT_IDX_W = 6;           // slot index field on the result
    localparam int MAG_W      = TILE_W + 1;  // magnitude of a tile, holds 32768
    localparam int IN_DATA_W  = 32;          // two tile fields
    localparam int OUT_DATA_W = 32;          // 28 bits of fields, zero filled

    // Defaults for the top-level parameters
    localparam int WINDOW_SIDE_DEF = 7;
    localparam int CHUNK_TILES_DEF = 32;

    // Operation codes carried on the input tuser
    localparam logic OP_CAMERA = 1'b0;
    localparam logic OP_WORLD  = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIVX  = 5'b00010,
        ST_DIVZ  = 5'b00100,
        ST_EVICT = 5'b01000,
        ST_WALK  = 5'b10000
    } t_state;

endpackage

>>> hdl/swcsm_div.sv
// Constant divider: tile coordinate to chunk coordinate, truncating toward zero.
// Depends on swcsm_pkg; magnitude times reciprocal; done registered from r_pend.
module swcsm_div
    import swcsm_pkg::*;
#(
    parameter int CHUNK_TILES = CHUNK_TILES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TILE_W-1:0]  i_tile,
    output logic               o_done,
    output logic [CHUNK_W-1:0] o_chunk
);

    // Reciprocal scaled so that the quotient is exact for every MAG_W-bit magnitude
    localparam int     SHIFT   = MAG_W + $clog2(CHUNK_TILES);
    localparam int     RECIP_W = MAG_W + 2;
    localparam int     PROD_W  = SHIFT + MAG_W;
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(CHUNK_TILES) - 1)
                                 / longint'(CHUNK_TILES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic              r_pend;
    logic              r_done;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;
    logic [MAG_W-1:0]  r_quo;

    logic [MAG_W-1:0]  w_ext;
    logic [MAG_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [MAG_W-1:0]  w_qs;

    // Take the magnitude of the signed tile
    assign w_ext = {i_tile[TILE_W-1], i_tile};
    assign w_mag = i_tile[TILE_W-1] ? (MAG_W'(0) - w_ext) : w_ext;

    // Multiply by the reciprocal and keep the integer part
    assign w_prod = PROD_W'(r_mag) * PROD_W'(RECIP);

    // Restore the sign and keep the low chunk bits
    assign w_qs    = r_neg ? (MAG_W'(0) - r_quo) : r_quo;
    assign o_chunk = w_qs[CHUNK_W-1:0];
    assign o_done  = r_done;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pend <= i_start;
            r_done <= r_pend;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= w_mag;
            r_neg <= i_tile[TILE_W-1];
        end
        if (r_pend) begin
            r_quo <= w_prod[PROD_W-1:SHIFT];
        end
    end

endmodule

>>> hdl/sliding_window_chunk_slot_manager_unit.sv
// Top level of the sliding-window chunk slot manager: sequencer, slot table, output register.
// Depends on swcsm_pkg and swcsm_div.
//
// A camera transfer (tuser = 0) carries a center tile; both axes are divided by CHUNK_TILES in
// the shared divider, one after the other. An unchanged center chunk ends there with no
// result. Otherwise, and for a world-load transfer (tuser = 1, tiles ignored, all slots freed),
// one pass reads the coordinate memory slot by slot, freeing slots that fell out of the window
// and marking the window positions still resident. The walk then visits each window position
// in turn, allocating a slot for each one not resident, and waits while the free-slot pointer
// skips occupied slots or the output register holds a result that is not taken. The input is
// ready only when the sequencer is idle; the last result may still sit in the output register
// while the next transfer is taken.
module sliding_window_chunk_slot_manager_unit
    import swcsm_pkg::*;
#(
    parameter int WINDOW_SIDE = WINDOW_SIDE_DEF,
    parameter int CHUNK_TILES = CHUNK_TILES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] center_tile_x, [31:16] center_tile_z
    input  logic                  s_axis_tuser,   // [0] operation
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] slot_index, [16:6] chunk_x,
                                                  // [27:17] chunk_z, [31:28] zero
    output logic                  m_axis_tlast    // last_of_burst
);

    localparam int SLOTS = WINDOW_SIDE * WINDOW_SIDE;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int POS_W = (WINDOW_SIDE > 1) ? $clog2(WINDOW_SIDE) : 1;
    localparam logic [CHUNK_W-1:0] HALF = CHUNK_W'(WINDOW_SIDE / 2);
    localparam logic [CHUNK_W-1:0] SIDE = CHUNK_W'(WINDOW_SIDE);

    t_state r_state;

    // Slot table
    logic [SLOTS-1:0]           r_valid;
    logic [2*CHUNK_W-1:0]       r_mem [SLOTS];
    logic [2*CHUNK_W-1:0]       r_rd_data;

    // Centers and divider handoff
    logic [CHUNK_W-1:0]         r_cx;
    logic [CHUNK_W-1:0]         r_cz;
    logic [CHUNK_W-1:0]         r_nx;
    logic [TILE_W-1:0]          r_tile_z;

    // Eviction pass
    logic [CNT_W-1:0]           r_idx;
    logic [CNT_W-1:0]           r_rd_idx;
    logic                       r_rd_pend;
    logic [WINDOW_SIDE-1:0]     r_map [WINDOW_SIDE];
    logic [CNT_W-1:0]           r_remain;

    // Window walk
    logic [POS_W-1:0]           r_a;
    logic [POS_W-1:0]           r_b;
    logic [CNT_W-1:0]           r_free;

    // Output register
    logic                       r_out_valid;
    logic [SLOT_IDX_W-1:0]      r_out_slot;
    logic [CHUNK_W-1:0]         r_out_x;
    logic [CHUNK_W-1:0]         r_out_z;
    logic                       r_out_last;

    // Divider connections
    logic                       w_div_start;
    logic [TILE_W-1:0]          w_div_tile;
    logic                       w_div_done;
    logic [CHUNK_W-1:0]         w_div_chunk;

    // Combinational helpers
    logic                       w_in_acc;
    logic [CHUNK_W-1:0]         w_lowx;
    logic [CHUNK_W-1:0]         w_lowz;
    logic [CHUNK_W-1:0]         w_dx;
    logic [CHUNK_W-1:0]         w_dz;
    logic                       w_keep;
    logic [CHUNK_W-1:0]         w_pos_x;
    logic [CHUNK_W-1:0]         w_pos_z;
    logic                       w_rd_en;
    logic                       w_resident;
    logic                       w_free_busy;
    logic                       w_out_free;
    logic                       w_alloc;
    logic                       w_advance;
    logic                       w_walk_end;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Start the divider on x at acceptance, on z when x is done
    assign w_div_start = (w_in_acc && (s_axis_tuser == OP_CAMERA)) ||
                         ((r_state == ST_DIVX) && w_div_done);
    assign w_div_tile  = (r_state == ST_IDLE) ? s_axis_tdata[TILE_W-1:0] : r_tile_z;

    swcsm_div #(
        .CHUNK_TILES (CHUNK_TILES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_tile  (w_div_tile),
        .o_done  (w_div_done),
        .o_chunk (w_div_chunk)
    );

    // Window low corner and membership of the slot just read
    assign w_lowx  = r_cx - HALF;
    assign w_lowz  = r_cz - HALF;
    assign w_dx    = r_rd_data[2*CHUNK_W-1:CHUNK_W] - w_lowx;
    assign w_dz    = r_rd_data[CHUNK_W-1:0] - w_lowz;
    assign w_keep  = (w_dx < SIDE) && (w_dz < SIDE);
    assign w_rd_en = (r_state == ST_EVICT) && (r_idx != CNT_W'(SLOTS));

    // Walk decisions
    assign w_pos_x     = w_lowx + CHUNK_W'(r_a);
    assign w_pos_z     = w_lowz + CHUNK_W'(r_b);
    assign w_resident  = r_map[r_a][r_b];
    assign w_free_busy = r_valid[r_free[IDX_W-1:0]];
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_alloc     = (r_state == ST_WALK) && !w_resident && !w_free_busy && w_out_free;
    assign w_advance   = (r_state == ST_WALK) && (w_resident || w_alloc);
    assign w_walk_end  = (r_a == POS_W'(WINDOW_SIDE - 1)) && (r_b == POS_W'(WINDOW_SIDE - 1));

    // Sequencer and slot bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_cx      <= '0;
            r_cz      <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (s_axis_tuser == OP_WORLD) begin
                            // World load: free everything, refill around the stored center
                            r_valid   <= '0;
                            r_idx     <= '0;
                            r_rd_pend <= 1'b0;
                            r_remain  <= CNT_W'(SLOTS);
                            for (int i = 0; i < WINDOW_SIDE; i++) begin
                                r_map[i] <= '0;
                            end
                            r_state <= ST_EVICT;
                        end else begin
                            r_tile_z <= s_axis_tdata[2*TILE_W-1:TILE_W];
                            r_state  <= ST_DIVX;
                        end
                    end
                end
                ST_DIVX: begin
                    if (w_div_done) begin
                        r_nx    <= w_div_chunk;
                        r_state <= ST_DIVZ;
                    end
                end
                ST_DIVZ: begin
                    if (w_div_done) begin
                        // Drop the transfer if the center chunk did not move
                        if (r_nx == r_cx && w_div_chunk == r_cz) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cx      <= r_nx;
                            r_cz      <= w_div_chunk;
                            r_idx     <= '0;
                            r_rd_pend <= 1'b0;
                            r_remain  <= CNT_W'(SLOTS);
                            for (int i = 0; i < WINDOW_SIDE; i++) begin
                                r_map[i] <= '0;
                            end
                            r_state <= ST_EVICT;
                        end
                    end
                end
                ST_EVICT: begin
                    // Issue one read per cycle, check the slot read the cycle before
                    r_rd_pend <= w_rd_en;
                    r_rd_idx  <= r_idx;
                    if (w_rd_en) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_rd_pend && r_valid[r_rd_idx[IDX_W-1:0]]) begin
                        if (w_keep) begin
                            r_map[w_dx[POS_W-1:0]][w_dz[POS_W-1:0]] <= 1'b1;
                            r_remain <= r_remain - 1'b1;
                        end else begin
                            r_valid[r_rd_idx[IDX_W-1:0]] <= 1'b0;
                        end
                    end
                    if (!w_rd_en && !r_rd_pend) begin
                        r_a     <= '0;
                        r_b     <= '0;
                        r_free  <= '0;
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    // Advance the free-slot pointer past occupied slots
                    if (!w_resident && w_free_busy) begin
                        r_free <= r_free + 1'b1;
                    end
                    if (w_alloc) begin
                        r_valid[r_free[IDX_W-1:0]] <= 1'b1;
                        r_free   <= r_free + 1'b1;
                        r_remain <= r_remain - 1'b1;
                    end
                    if (w_advance) begin
                        if (w_walk_end) begin
                            r_state <= ST_IDLE;
                        end else if (r_b == POS_W'(WINDOW_SIDE - 1)) begin
                            r_b <= '0;
                            r_a <= r_a + 1'b1;
                        end else begin
                            r_b <= r_b + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Coordinate memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_alloc) begin
            r_mem[r_free[IDX_W-1:0]] <= {w_pos_x, w_pos_z};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    // Output register: load on allocation, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_alloc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_alloc) begin
            r_out_slot <= SLOT_IDX_W'(r_free);
            r_out_x    <= w_pos_x;
            r_out_z    <= w_pos_z;
            r_out_last <= (r_remain == CNT_W'(1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {(OUT_DATA_W - SLOT_IDX_W - 2 * CHUNK_W)'(0),
                            r_out_z, r_out_x, r_out_slot};

endmodule
